// ----- hdl/summed_area_table_query_defines.svh -----
// Assertion macros for the summed-area table query block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SUMMED_AREA_TABLE_QUERY_DEFINES_SVH
`define SUMMED_AREA_TABLE_QUERY_DEFINES_SVH

`ifndef SYNTH
// plain property, checked every cycle out of reset
`define SAT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent implies consequent (consequent may carry a fixed delay)
`define SAT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) else $error(msg);
`else
`define SAT_ASSERT(lbl, clk, rstn, prop, msg)
`define SAT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- hdl/sat_pkg.sv -----
// Shared types, codes and helpers for the summed-area table query block.
// No dependencies; imported by sat_core, summed_area_table_query and tb_top.
package sat_pkg;

    localparam int CNT_W = 7;
    localparam int COORD_W = 6;
    localparam int ELEM_W = 16;
    localparam int RESULT_W = 32;

    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    // item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register indexes
    localparam logic [0:0] REG_ROW_COUNT = 1'b0;
    localparam logic [0:0] REG_COL_COUNT = 1'b1;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] row_count;
        logic [CNT_W-1:0] col_count;
        logic             restart;    // a register write rewinds the load position
    } sat_cfg_t;

    // zero reads as one, anything above the array size saturates
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input int unsigned max_cnt);
        logic [CNT_W-1:0] res;
        res = v;
        if (v == '0)
            res = CNT_W'(1);
        else if (32'(v) > max_cnt)
            res = CNT_W'(max_cnt);
        return res;
    endfunction

endpackage

// ----- hdl/sat_mem.sv -----
// Single-port synchronous table memory with a registered read.
// No dependencies; used by summed_area_table_query.
module sat_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic [AW-1:0]    addr,
    input  logic             we,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sat_core.sv -----
// Load/query sequencer: builds table entries and walks the four query corners.
// Depends on sat_pkg and the assertion macros; drives the port of sat_mem.
`include "summed_area_table_query_defines.svh"

module sat_core
    import sat_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int SUM_WIDTH = 32,
    parameter int AW        = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sat_cfg_t                   cfg,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic signed [ELEM_W-1:0]   elem_value,
    input  logic [COORD_W-1:0]         top_row,
    input  logic [COORD_W-1:0]         left_col,
    input  logic [COORD_W-1:0]         bottom_row,
    input  logic [COORD_W-1:0]         right_col,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [RESULT_W-1:0] rect_sum,
    output logic                       status,
    output logic [AW-1:0]              mem_addr,
    output logic                       mem_we,
    output logic [SUM_WIDTH-1:0]       mem_wdata,
    input  logic [SUM_WIDTH-1:0]       mem_rdata
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW_A  = (RW > CW) ? RW : CW;
    localparam int PW    = (PW_A > COORD_W) ? PW_A : COORD_W;
    localparam int CMP_W = ((PW > CNT_W) ? PW : CNT_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_QA,
        S_QB,
        S_QC,
        S_QD,
        S_QE,
        S_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic [RW-1:0]               ld_row_reg, ld_row_next;
    logic [CW-1:0]               ld_col_reg, ld_col_next;
    logic [SUM_WIDTH-1:0]        rsum_reg, rsum_next;
    logic [SUM_WIDTH-1:0]        acc_reg, acc_next;
    logic                        err_reg, err_next;
    logic [COORD_W-1:0]          t_reg, t_next;
    logic [COORD_W-1:0]          l_reg, l_next;
    logic [COORD_W-1:0]          b_reg, b_next;
    logic [COORD_W-1:0]          r_reg, r_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [RESULT_W-1:0]  rect_sum_reg, rect_sum_next;
    logic                        status_reg, status_next;

    logic                        in_acc;
    logic                        out_free;
    logic                        bad_coord;
    logic [SUM_WIDTH-1:0]        elem_ext;
    logic [COORD_W-1:0]          t_m1;
    logic [COORD_W-1:0]          l_m1;
    logic [CMP_W-1:0]            col_inc;
    logic [CMP_W-1:0]            row_inc;

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] r, input logic [PW-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    assign in_acc    = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign elem_ext  = SUM_WIDTH'(elem_value);
    assign bad_coord = ({1'b0, top_row} >= cfg.row_count) || ({1'b0, bottom_row} >= cfg.row_count)
                    || ({1'b0, left_col} >= cfg.col_count) || ({1'b0, right_col} >= cfg.col_count);
    // dropped corner terms keep a legal address; their data is masked later
    assign t_m1      = (t_reg != '0) ? t_reg - 1'b1 : t_reg;
    assign l_m1      = (l_reg != '0) ? l_reg - 1'b1 : l_reg;
    assign col_inc   = CMP_W'(ld_col_reg) + CMP_W'(1);
    assign row_inc   = CMP_W'(ld_row_reg) + CMP_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        ld_row_next    = ld_row_reg;
        ld_col_next    = ld_col_reg;
        rsum_next      = rsum_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        t_next         = t_reg;
        l_next         = l_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg;
        rect_sum_next  = rect_sum_reg;
        status_next    = status_reg;
        mem_addr       = '0;
        mem_we         = 1'b0;
        mem_wdata      = rsum_reg + ((ld_row_reg != '0) ? mem_rdata : '0);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (op == OP_LOAD)
                    begin
                        rsum_next  = ((ld_col_reg == '0) ? '0 : rsum_reg) + elem_ext;
                        state_next = S_LD_RD;
                    end
                    else
                    begin
                        t_next = top_row;
                        l_next = left_col;
                        b_next = bottom_row;
                        r_next = right_col;
                        if (bad_coord)
                        begin
                            acc_next   = '0;
                            err_next   = STATUS_ERR;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            err_next   = STATUS_OK;
                            state_next = S_QA;
                        end
                    end
                end
            end
            S_LD_RD:
            begin
                // entry directly above; row 0 reads itself and ignores the data
                mem_addr   = addr_of(PW'((ld_row_reg != '0) ? ld_row_reg - 1'b1 : ld_row_reg),
                                     PW'(ld_col_reg));
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                mem_addr   = addr_of(PW'(ld_row_reg), PW'(ld_col_reg));
                mem_we     = 1'b1;
                state_next = S_IDLE;
                if (col_inc >= CMP_W'(cfg.col_count))
                begin
                    ld_col_next = '0;
                    if (row_inc >= CMP_W'(cfg.row_count))
                        ld_row_next = '0;
                    else
                        ld_row_next = RW'(row_inc);
                end
                else
                begin
                    ld_col_next = CW'(col_inc);
                end
            end
            S_QA:
            begin
                mem_addr   = addr_of(PW'(b_reg), PW'(r_reg));
                state_next = S_QB;
            end
            S_QB:
            begin
                mem_addr   = addr_of(PW'(b_reg), PW'(l_m1));
                acc_next   = mem_rdata;
                state_next = S_QC;
            end
            S_QC:
            begin
                mem_addr   = addr_of(PW'(t_m1), PW'(r_reg));
                acc_next   = acc_reg - ((l_reg != '0) ? mem_rdata : '0);
                state_next = S_QD;
            end
            S_QD:
            begin
                mem_addr   = addr_of(PW'(t_m1), PW'(l_m1));
                acc_next   = acc_reg - ((t_reg != '0) ? mem_rdata : '0);
                state_next = S_QE;
            end
            S_QE:
            begin
                acc_next   = acc_reg + (((t_reg != '0) && (l_reg != '0)) ? mem_rdata : '0);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rect_sum_next  = signed'(RESULT_W'(acc_reg));
                    status_next    = err_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase

        if (cfg.restart)
        begin
            ld_row_next = '0;
            ld_col_next = '0;
            rsum_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ld_row_reg    <= '0;
            ld_col_reg    <= '0;
            rsum_reg      <= '0;
            acc_reg       <= '0;
            err_reg       <= STATUS_OK;
            t_reg         <= '0;
            l_reg         <= '0;
            b_reg         <= '0;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
            rect_sum_reg  <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            ld_row_reg    <= ld_row_next;
            ld_col_reg    <= ld_col_next;
            rsum_reg      <= rsum_next;
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            t_reg         <= t_next;
            l_reg         <= l_next;
            b_reg         <= b_next;
            r_reg         <= r_next;
            out_valid_reg <= out_valid_next;
            rect_sum_reg  <= rect_sum_next;
            status_reg    <= status_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign rect_sum  = rect_sum_reg;
    assign status    = status_reg;

    // every accepted load writes its entry in the write-back state after the read of the entry above
    `SAT_ASSERT_IMP(a_load_writes, clk, rst_n, in_valid && !in_stall && op == OP_LOAD, ##2 mem_we, "load did not write its table entry")
    // load position never leaves the configured size
    `SAT_ASSERT(a_pos_in_range, clk, rst_n, (CMP_W'(ld_row_reg) < CMP_W'(cfg.row_count)) && (CMP_W'(ld_col_reg) < CMP_W'(cfg.col_count)), "load position outside configured size")
    // a flagged result carries a zero sum
    `SAT_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid_reg && status_reg == STATUS_ERR, rect_sum_reg == '0, "error result with nonzero sum")

endmodule

// ----- hdl/summed_area_table_query.sv -----
// Top level of the summed-area table query block: config registers, sequencer, table memory.
// Depends on sat_pkg, sat_core and sat_mem.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | in        | in_valid / in_stall | op, elem_value, top_row, left_col,
//           |           |                     | bottom_row, right_col
//   out     | out       | out_valid/out_stall | rect_sum, status
//   cfg     | in        | cfg_we              | cfg_index, cfg_wdata
//
// A load passes through accept, read of the entry above and write-back; a query through
// accept, four corner reads on the single table port, final add and hand-off to the output.
// A query with a coordinate outside the configured size skips the reads and the add.
// The output register holds one result; the next item is accepted while it waits, and a
// query that finishes while it is still full waits for it. Reset clears control and
// the load position and presets the sizes, not the table: entries are valid once loaded.
module summed_area_table_query
    import sat_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int SUM_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [CNT_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic signed [ELEM_W-1:0]   elem_value,
    input  logic [COORD_W-1:0]         top_row,
    input  logic [COORD_W-1:0]         left_col,
    input  logic [COORD_W-1:0]         bottom_row,
    input  logic [COORD_W-1:0]         right_col,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [RESULT_W-1:0] rect_sum,
    output logic                       status
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]     row_count_reg;
    logic [CNT_W-1:0]     col_count_reg;
    sat_cfg_t             cfg;
    logic [AW-1:0]        mem_addr;
    logic                 mem_we;
    logic [SUM_WIDTH-1:0] mem_wdata;
    logic [SUM_WIDTH-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= clamp_count(CNT_RESET, MAX_ROWS);
            col_count_reg <= clamp_count(CNT_RESET, MAX_COLS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= clamp_count(cfg_wdata, MAX_ROWS);
                REG_COL_COUNT: col_count_reg <= clamp_count(cfg_wdata, MAX_COLS);
            endcase
        end
    end

    assign cfg.row_count = row_count_reg;
    assign cfg.col_count = col_count_reg;
    assign cfg.restart   = cfg_we;

    sat_core #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .SUM_WIDTH (SUM_WIDTH),
        .AW        (AW)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .elem_value (elem_value),
        .top_row    (top_row),
        .left_col   (left_col),
        .bottom_row (bottom_row),
        .right_col  (right_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rect_sum   (rect_sum),
        .status     (status),
        .mem_addr   (mem_addr),
        .mem_we     (mem_we),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

    sat_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SUM_WIDTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for summed_area_table_query: loads tables in raster order,
// issues rectangle queries and checks every result against a table model kept in the bench.
// Depends on sat_pkg and the summed_area_table_query RTL.
module tb_top;
    import sat_pkg::*;

    localparam int TBL_ROWS   = 64;
    localparam int TBL_COLS   = 64;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 12;
    localparam int PHASES     = 16;

    typedef struct {
        logic                     op;
        logic signed [ELEM_W-1:0] elem_value;
        logic [COORD_W-1:0]       top_row;
        logic [COORD_W-1:0]       left_col;
        logic [COORD_W-1:0]       bottom_row;
        logic [COORD_W-1:0]       right_col;
    } sat_item_t;

    typedef struct {
        logic signed [RESULT_W-1:0] rect_sum;
        logic                       status;
    } sat_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [0:0]                 cfg_index = REG_ROW_COUNT;
    logic [CNT_W-1:0]           cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       op = OP_LOAD;
    logic signed [ELEM_W-1:0]   elem_value = '0;
    logic [COORD_W-1:0]         top_row = '0;
    logic [COORD_W-1:0]         left_col = '0;
    logic [COORD_W-1:0]         bottom_row = '0;
    logic [COORD_W-1:0]         right_col = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [RESULT_W-1:0] rect_sum;
    logic                       status;

    // table model, updated as transactions are accepted
    logic [RESULT_W-1:0] area_mirror [TBL_ROWS*TBL_COLS];
    int                  mirror_row = 0;
    int                  mirror_col = 0;
    logic [RESULT_W-1:0] mirror_run = '0;
    int                  rows_in_use = TBL_ROWS;
    int                  cols_in_use = TBL_COLS;

    // generator-side view of which entries hold data since reset
    bit                  loaded_map [TBL_ROWS*TBL_COLS];
    int                  gen_row = 0;
    int                  gen_col = 0;

    sat_item_t   pending_items [$];
    sat_result_t expected_sums [$];
    sat_item_t   offered_item;

    int          sender_idle_pct = 18;
    int          receiver_idle_pct = 72;
    int          queries_taken = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          fail_count = 0;
    int unsigned cycle_cnt = 0;

    summed_area_table_query i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .elem_value (elem_value),
        .top_row    (top_row),
        .left_col   (left_col),
        .bottom_row (bottom_row),
        .right_col  (right_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rect_sum   (rect_sum),
        .status     (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit note_fail();
        fail_count++;
        return fail_count <= 100;
    endfunction

    function automatic bit was_loaded(input int r, input int c);
        return loaded_map[r*TBL_COLS + c];
    endfunction

    // a register write clamps its value and rewinds the load position
    task automatic note_size(input logic [0:0] idx, input logic [CNT_W-1:0] v);
        int n;
        n = (v == '0) ? 1 : ((int'(v) > TBL_ROWS) ? TBL_ROWS : int'(v));
        if (idx == REG_ROW_COUNT)
            rows_in_use = n;
        else
            cols_in_use = n;
        mirror_row = 0;
        mirror_col = 0;
        mirror_run = '0;
        gen_row = 0;
        gen_col = 0;
    endtask

    task automatic set_size(input bit wr_rows, input logic [CNT_W-1:0] rows_v,
                            input bit wr_cols, input logic [CNT_W-1:0] cols_v);
        if (wr_rows)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ROW_COUNT;
            cfg_wdata <= rows_v;
            @(posedge clk);
            note_size(REG_ROW_COUNT, rows_v);
        end
        if (wr_cols)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_COL_COUNT;
            cfg_wdata <= cols_v;
            @(posedge clk);
            note_size(REG_COL_COUNT, cols_v);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic push_load(input logic signed [ELEM_W-1:0] v);
        sat_item_t it;
        it.op         = OP_LOAD;
        it.elem_value = v;
        it.top_row    = COORD_W'($urandom);
        it.left_col   = COORD_W'($urandom);
        it.bottom_row = COORD_W'($urandom);
        it.right_col  = COORD_W'($urandom);
        pending_items.push_back(it);
        if (gen_row >= rows_in_use || gen_col >= cols_in_use)
        begin
            gen_row = 0;
            gen_col = 0;
        end
        loaded_map[gen_row*TBL_COLS + gen_col] = 1'b1;
        gen_col++;
        if (gen_col >= cols_in_use)
        begin
            gen_col = 0;
            gen_row++;
            if (gen_row >= rows_in_use)
                gen_row = 0;
        end
    endtask

    task automatic push_query(input int t, input int l, input int b, input int r);
        sat_item_t it;
        it.op         = OP_QUERY;
        it.elem_value = ELEM_W'($urandom);
        it.top_row    = COORD_W'(t);
        it.left_col   = COORD_W'(l);
        it.bottom_row = COORD_W'(b);
        it.right_col  = COORD_W'(r);
        pending_items.push_back(it);
    endtask

    // in-range corners only where every entry read holds data; else an out-of-size query, if the size allows
    task automatic push_rand_query(input int rlim);
        int  t, l, b, r, k;
        bit  ok, can_err;
        ok = 1'b0;
        can_err = (rows_in_use < TBL_ROWS) || (cols_in_use < TBL_COLS);
        if (rlim > rows_in_use - 1)
            rlim = rows_in_use - 1;
        if (!(can_err && $urandom_range(0, 3) == 0))
        begin
            for (k = 0; k < 16 && !ok; k++)
            begin
                t = $urandom_range(0, rlim);
                b = $urandom_range(0, rlim);
                l = $urandom_range(0, cols_in_use - 1);
                r = $urandom_range(0, cols_in_use - 1);
                ok = was_loaded(b, r) && (l == 0 || was_loaded(b, l - 1))
                     && (t == 0 || was_loaded(t - 1, r))
                     && (t == 0 || l == 0 || was_loaded(t - 1, l - 1));
            end
        end
        if (ok)
            push_query(t, l, b, r);
        else if (can_err)
        begin
            t = $urandom_range(0, 63);
            l = $urandom_range(0, 63);
            b = $urandom_range(0, 63);
            r = $urandom_range(0, 63);
            if (rows_in_use < TBL_ROWS && (cols_in_use == TBL_COLS || $urandom_range(0, 1)))
            begin
                if ($urandom_range(0, 1))
                    t = $urandom_range(rows_in_use, 63);
                else
                    b = $urandom_range(rows_in_use, 63);
            end
            else
            begin
                if ($urandom_range(0, 1))
                    l = $urandom_range(cols_in_use, 63);
                else
                    r = $urandom_range(cols_in_use, 63);
            end
            push_query(t, l, b, r);
        end
    endtask

    // build the table entry for a load, or the rectangle sum for a query
    task automatic apply_to_mirror(input sat_item_t it);
        logic [RESULT_W-1:0] ext, s;
        sat_result_t         res;
        int                  t, l, b, r;
        if (it.op == OP_LOAD)
        begin
            ext = {{(RESULT_W-ELEM_W){it.elem_value[ELEM_W-1]}}, it.elem_value};
            if (mirror_row >= rows_in_use || mirror_col >= cols_in_use)
            begin
                mirror_row = 0;
                mirror_col = 0;
            end
            if (mirror_col == 0)
                mirror_run = '0;
            mirror_run = mirror_run + ext;
            s = mirror_run;
            if (mirror_row > 0)
                s = s + area_mirror[(mirror_row - 1)*TBL_COLS + mirror_col];
            area_mirror[mirror_row*TBL_COLS + mirror_col] = s;
            mirror_col++;
            if (mirror_col >= cols_in_use)
            begin
                mirror_col = 0;
                mirror_row++;
                if (mirror_row >= rows_in_use)
                    mirror_row = 0;
            end
        end
        else
        begin
            t = int'(it.top_row);
            l = int'(it.left_col);
            b = int'(it.bottom_row);
            r = int'(it.right_col);
            if (t >= rows_in_use || b >= rows_in_use || l >= cols_in_use || r >= cols_in_use)
            begin
                res.rect_sum = '0;
                res.status   = STATUS_ERR;
            end
            else
            begin
                s = area_mirror[b*TBL_COLS + r];
                if (l != 0)
                    s = s - area_mirror[b*TBL_COLS + l - 1];
                if (t != 0)
                    s = s - area_mirror[(t - 1)*TBL_COLS + r];
                if (t != 0 && l != 0)
                    s = s + area_mirror[(t - 1)*TBL_COLS + l - 1];
                res.rect_sum = s;
                res.status   = STATUS_OK;
            end
            expected_sums.push_back(res);
        end
    endtask

    // driver: presents the next pending transaction, holds it while stalled
    always @(posedge clk)
    begin : drive_proc
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                apply_to_mirror(offered_item);
                if (offered_item.op == OP_QUERY)
                    queries_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    offered_item = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    op         <= offered_item.op;
                    elem_value <= offered_item.elem_value;
                    top_row    <= offered_item.top_row;
                    left_col   <= offered_item.left_col;
                    bottom_row <= offered_item.bottom_row;
                    right_col  <= offered_item.right_col;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off once queries are flowing
    always @(posedge clk)
    begin : stall_proc
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && queries_taken >= 40)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    always @(posedge clk)
    begin : check_proc
        sat_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sums.size() == 0)
            begin
                if (note_fail())
                    $display("%0t: unexpected result rect_sum %0d status %0d",
                             $time, rect_sum, status);
            end
            else
            begin
                want = expected_sums.pop_front();
                if (rect_sum !== want.rect_sum && note_fail())
                    $display("%0t: rect_sum mismatch, expected %0d, got %0d",
                             $time, want.rect_sum, rect_sum);
                if (status !== want.status && note_fail())
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, status);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog_proc
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP)
        begin
            $display("summed_area_table_query test failed");
            $finish;
        end
    end

    // drained: nothing queued, nothing offered, nothing outstanding, then the load pipe settles
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin : stim_proc
        int n_loads, rlim, k;
        bit wr_r, wr_c;
        logic [CNT_W-1:0] rows_w, cols_w;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 2x3 table with extreme values, corner cases, then a wrapped load
        set_size(1'b1, 7'd2, 1'b1, 7'd3);
        push_load(16'sh7fff);
        push_load(16'sh8000);
        push_load(-16'sd1);
        push_load(16'sd0);
        push_load(16'sd1);
        push_load(16'sh7fff);
        push_query(0, 0, 1, 2);
        push_query(1, 2, 1, 2);
        push_query(0, 0, 0, 0);
        push_query(1, 2, 0, 0);     // inverted corners
        push_query(1, 1, 0, 0);
        push_query(2, 0, 1, 2);     // row just past the size
        push_query(0, 3, 1, 2);     // column just past the size
        push_query(0, 0, 63, 63);
        push_query(63, 63, 63, 63);
        push_load(16'sh8000);       // wraps to the first entry
        push_query(0, 0, 0, 0);
        push_query(0, 0, 1, 2);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            if (ph == 6)
            begin
                sender_idle_pct   = 72;
                receiver_idle_pct = 18;
            end
            else if (ph == 11)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            wr_r = 1'b1;
            wr_c = 1'b1;
            rows_w = CNT_W'($urandom_range(1, 8));
            cols_w = CNT_W'($urandom_range(1, 8));
            case (ph)
                0: begin rows_w = 7'd1;   cols_w = 7'd1;   end
                1: begin rows_w = 7'd127; cols_w = 7'd1;   end
                2: begin rows_w = 7'd0;   cols_w = 7'd100; end
                3: begin rows_w = 7'd64;  cols_w = 7'd64;  end
                4: begin wr_r = 1'b0;     cols_w = 7'd2;   end
                5: wr_c = 1'b0;
                default: ;
            endcase
            set_size(wr_r, rows_w, wr_c, cols_w);
            // full 64x64 is too long to fill; two rows are loaded and queried there
            n_loads = (ph == 3) ? 2*TBL_COLS : rows_in_use*cols_in_use;
            rlim    = (ph == 3) ? 1 : rows_in_use - 1;
            for (k = 0; k < n_loads; k++)
                push_load(ELEM_W'($urandom));
            for (k = 0; k < 20; k++)
                push_rand_query(rlim);
            // mixed tail: partial reloads over the table and queries in between
            for (k = 0; k < 10; k++)
            begin
                if ($urandom_range(0, 1))
                    push_load(ELEM_W'($urandom));
                else
                    push_rand_query(rlim);
            end
        end

        wait_idle();
        if (fail_count == 0 && expected_sums.size() == 0)
            $display("summed_area_table_query test passed");
        else
            $display("summed_area_table_query test failed");
        $finish;
    end

endmodule
